FILE: hdl/bitmap_slot_store_defines.svh
// Assertion macros for the slot store; each expects clk and arst_n in scope.
`ifndef BITMAP_SLOT_STORE_DEFINES_SVH
`define BITMAP_SLOT_STORE_DEFINES_SVH

// cond holds at every edge outside reset
`define BSS_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define BSS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bss_pkg.sv
// Package: types and constants of the bitmap slot store.
package bss_pkg;

	localparam int IDX_W          = 6;
	localparam int VALUE_W        = 64;
	localparam int ROW_BITS       = 1 << IDX_W;
	localparam int SLOT_COUNT_DEF = 64;
	localparam int TDATA_W        = ((IDX_W + VALUE_W + 7) / 8) * 8;
	localparam int TDATA_PAD      = TDATA_W - IDX_W - VALUE_W;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_SET   = 2'd1,
		REQ_GET   = 2'd2,
		REQ_FREE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_UNALLOC = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

endpackage

FILE: hdl/bitmap_slot_store.sv
// Top level: slot allocator with occupancy bitmap and value store.
// Each request is accepted and then executed: on acceptance the bitmap row and
// value entry are read from their synchronous memories; in the next cycle
// the block decides, writes back the memories the request changes and loads
// the result register. The result register must be free (or drained that
// cycle) for execution to complete; a stalled output holds execution. The next
// request is accepted while a result still waits. The bitmap is kept in
// rows of 64 bits; per-row valid and full flags replace a clearing pass, so
// the block is ready right after reset. Allocate picks the lowest row that
// is not full, then the lowest free bit in it. For tables beyond 64 slots
// slot_out carries the low 6 bits of the granted slot, and set, get and
// free reach only the first 64 slots.
`include "bitmap_slot_store_defines.svh"

module bitmap_slot_store
	import bss_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // slot_index[5:0], write_value[69:6], zero pad
	input  logic [1:0]         s_tuser,  // req_type[1:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // slot_out[5:0], read_value[69:6], zero pad
	output logic [1:0]         m_tuser   // status[1:0]
);

	localparam int ROWS   = (SLOT_COUNT + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int VAL_AW = $clog2(SLOT_COUNT);
	localparam int ADDR_W = ROW_AW + IDX_W;

	state_t state_q, state_d;

	logic [ROWS-1:0]    row_full_q;
	logic [ROWS-1:0]    row_valid_q;
	logic               all_full_q;
	req_t               req_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VALUE_W-1:0] wval_q;
	logic [ROW_AW-1:0]  row_q;

	logic [ROW_BITS-1:0] occ_mem [ROWS];
	logic [ROW_BITS-1:0] occ_rd_q;
	logic [VALUE_W-1:0]  val_mem [SLOT_COUNT];
	logic [VALUE_W-1:0]  val_rd_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [IDX_W-1:0]   slot_q;
	logic [VALUE_W-1:0] read_value_q;

	// accept side
	req_t               in_req;
	logic [IDX_W-1:0]   in_idx;
	logic [VALUE_W-1:0] in_wval;
	logic               accept;
	logic [ROW_AW-1:0]  free_row;
	logic [ROW_AW-1:0]  rd_row;
	logic [ADDR_W-1:0]  rd_addr_full;

	// execute side
	logic                exec_go;
	logic [ROW_BITS-1:0] word;
	logic [ROW_BITS-1:0] pad;
	logic [ROW_BITS-1:0] used_word;
	logic [IDX_W-1:0]    free_bit;
	logic                slot_used;
	logic                occ_we;
	logic [ROW_BITS-1:0] occ_wdata;
	logic                val_we;
	logic [ADDR_W-1:0]   wr_addr_full;
	logic [VALUE_W-1:0]  val_wdata;
	status_t             status_d;
	logic [IDX_W-1:0]    slot_d;
	logic [VALUE_W-1:0]  rval_d;

	assign in_req  = req_t'(s_tuser);
	assign in_idx  = s_tdata[IDX_W-1:0];
	assign in_wval = s_tdata[IDX_W+VALUE_W-1:IDX_W];

	// lowest row that still has a free slot
	always_comb begin
		free_row = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (!row_full_q[r]) begin
				free_row = ROW_AW'(r);
			end
		end
	end

	assign rd_row       = (in_req == REQ_ALLOC) ? free_row : '0;
	assign rd_addr_full = {ROW_AW'(0), in_idx};

	// slots past the table end count as used
	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			pad[b] = int'({row_q, IDX_W'(b)}) >= SLOT_COUNT;
		end
	end

	assign word      = row_valid_q[row_q] ? occ_rd_q : '0;
	assign used_word = word | pad;
	assign slot_used = (int'(idx_q) < SLOT_COUNT) && word[idx_q];

	always_comb begin
		free_bit = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (!used_word[b]) begin
				free_bit = IDX_W'(b);
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		accept       = 1'b0;
		exec_go      = 1'b0;
		occ_we       = 1'b0;
		occ_wdata    = word;
		val_we       = 1'b0;
		wr_addr_full = {ROW_AW'(0), idx_q};
		val_wdata    = wval_q;
		status_d     = ST_OK;
		slot_d       = idx_q;
		rval_d       = '0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				accept   = s_tvalid;
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				exec_go = !out_valid_q || m_tready;
				if (req_q == REQ_ALLOC) begin
					if (all_full_q) begin
						status_d = ST_FULL;
						slot_d   = '0;
					end else begin
						slot_d       = free_bit;
						occ_we       = exec_go;
						occ_wdata    = word | (ROW_BITS'(1) << free_bit);
						val_we       = exec_go;
						wr_addr_full = {row_q, free_bit};
						val_wdata    = '0;
					end
				end else if (!slot_used) begin
					status_d = ST_UNALLOC;
				end else begin
					case (req_q)
						REQ_SET: begin
							val_we = exec_go;
						end
						REQ_GET: begin
							rval_d = val_rd_q;
						end
						REQ_FREE: begin
							occ_we    = exec_go;
							occ_wdata = word & ~(ROW_BITS'(1) << idx_q);
						end
						default: begin
						end
					endcase
				end
				if (exec_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_full_q  <= '0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (occ_we) begin
				row_full_q[row_q]  <= &(occ_wdata | pad);
				row_valid_q[row_q] <= 1'b1;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= in_req;
			idx_q      <= in_idx;
			wval_q     <= in_wval;
			row_q      <= rd_row;
			all_full_q <= &row_full_q;
		end
		if (exec_go) begin
			status_q     <= status_d;
			slot_q       <= slot_d;
			read_value_q <= rval_d;
		end
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[row_q] <= occ_wdata;
		end
		if (accept) begin
			occ_rd_q <= occ_mem[rd_row];
		end
	end

	// value memory
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[wr_addr_full[VAL_AW-1:0]] <= val_wdata;
		end
		if (accept) begin
			val_rd_q <= val_mem[rd_addr_full[VAL_AW-1:0]];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{TDATA_PAD{1'b0}}, read_value_q, slot_q};
	assign m_tuser  = status_q;

	`BSS_ASSERT_NEXT(a_accept_to_exec, s_tvalid && s_tready, state_q == S_EXEC, "accepted beat not executed")
	`BSS_ASSERT_NEXT(a_full_result, exec_go && req_q == REQ_ALLOC && all_full_q, m_tvalid && status_q == ST_FULL && slot_q == '0, "bad full result")
	`BSS_ASSERT_NEXT(a_rval_zero, exec_go && req_q != REQ_GET, read_value_q == '0, "nonzero value on non-get")
	`BSS_ASSERT_SAME(a_write_in_exec, occ_we || val_we, exec_go, "memory write outside execute")

endmodule

FILE: dv/bitmap_slot_store_tb.sv
// Testbench for bitmap_slot_store: directed table plus random requests, scored by a slot predictor.
module bitmap_slot_store_tb
	import bss_pkg::*;
();

	localparam int SLOTS          = SLOT_COUNT_DEF;
	localparam int TIMEOUT_CYCLES = 200_000;
	localparam int PHASE_ITEMS    = 400;
	localparam int PRESSURE_ITEMS = 200;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_PRINTS     = 100;
	localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [VALUE_W-1:0] VAL_ALT = {(VALUE_W/2){2'b01}};

	typedef struct packed {
		status_t              status;
		logic [IDX_W-1:0]     slot;
		logic [VALUE_W-1:0]   value;
	} slot_result_t;

	typedef struct packed {
		req_t                 req;
		logic [IDX_W-1:0]     idx;
		logic [VALUE_W-1:0]   wval;
		logic                 typed;
		slot_result_t         want;
	} stim_row_t;

	typedef enum logic [1:0] {
		MIX_FILL  = 2'd0,
		MIX_DRAIN = 2'd1,
		MIX_EVEN  = 2'd2
	} mix_t;

	localparam slot_result_t NO_CHECK = '{ST_OK, 6'd0, 64'd0};

	stim_row_t directed_rows [21] = '{
		'{REQ_GET,   6'd0,  64'd0,   1'b1, '{ST_UNALLOC, 6'd0,  64'd0}},
		'{REQ_FREE,  6'd63, 64'd0,   1'b1, '{ST_UNALLOC, 6'd63, 64'd0}},
		'{REQ_SET,   6'd37, VAL_MAX, 1'b1, '{ST_UNALLOC, 6'd37, 64'd0}},
		'{REQ_ALLOC, 6'd63, VAL_MAX, 1'b1, '{ST_OK,      6'd0,  64'd0}},
		'{REQ_ALLOC, 6'd0,  64'd0,   1'b1, '{ST_OK,      6'd1,  64'd0}},
		'{REQ_SET,   6'd0,  VAL_MAX, 1'b1, '{ST_OK,      6'd0,  64'd0}},
		'{REQ_GET,   6'd0,  64'd0,   1'b1, '{ST_OK,      6'd0,  VAL_MAX}},
		'{REQ_SET,   6'd1,  VAL_MIN, 1'b1, '{ST_OK,      6'd1,  64'd0}},
		'{REQ_GET,   6'd1,  VAL_MAX, 1'b1, '{ST_OK,      6'd1,  VAL_MIN}},
		'{REQ_SET,   6'd1,  '1,      1'b0, NO_CHECK},
		'{REQ_GET,   6'd1,  64'd0,   1'b0, NO_CHECK},
		'{REQ_FREE,  6'd0,  '1,      1'b1, '{ST_OK,      6'd0,  64'd0}},
		'{REQ_GET,   6'd0,  64'd0,   1'b1, '{ST_UNALLOC, 6'd0,  64'd0}},
		'{REQ_FREE,  6'd0,  64'd0,   1'b1, '{ST_UNALLOC, 6'd0,  64'd0}},
		'{REQ_ALLOC, 6'd42, 64'd0,   1'b1, '{ST_OK,      6'd0,  64'd0}},
		'{REQ_GET,   6'd0,  64'd0,   1'b1, '{ST_OK,      6'd0,  64'd0}},
		'{REQ_SET,   6'd0,  VAL_ALT, 1'b0, NO_CHECK},
		'{REQ_GET,   6'd0,  64'd0,   1'b0, NO_CHECK},
		'{REQ_FREE,  6'd1,  64'd0,   1'b1, '{ST_OK,      6'd1,  64'd0}},
		'{REQ_SET,   6'd63, VAL_MIN, 1'b1, '{ST_UNALLOC, 6'd63, 64'd0}},
		'{REQ_FREE,  6'd0,  64'd0,   1'b1, '{ST_OK,      6'd0,  64'd0}}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;
	logic [1:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic [1:0]         m_tuser;

	logic [SLOTS-1:0]   slot_used;
	logic [VALUE_W-1:0] slot_value [SLOTS];
	slot_result_t       pending_results [$];

	logic               beat_typed;
	slot_result_t       beat_want;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 hold_left;
	mix_t               burst_mix;
	int                 burst_left;

	int mismatches;
	int results_checked;
	int req_count [4];
	int full_replies;
	int unalloc_replies;
	int peak_used;

	bitmap_slot_store #(.SLOT_COUNT(SLOTS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic slot_result_t serve_request(input req_t req, input logic [IDX_W-1:0] idx,
			input logic [VALUE_W-1:0] wval);
		slot_result_t r;
		int grant;
		r.status = ST_OK;
		r.slot = idx;
		r.value = '0;
		if (req == REQ_ALLOC) begin
			grant = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!slot_used[i])
					grant = i;
			if (grant < 0) begin
				r.status = ST_FULL;
				r.slot = '0;
				full_replies++;
			end else begin
				slot_used[grant] = 1'b1;
				slot_value[grant] = '0;
				r.slot = grant[IDX_W-1:0];
			end
		end else if (int'(idx) >= SLOTS || !slot_used[idx]) begin
			r.status = ST_UNALLOC;
			unalloc_replies++;
		end else begin
			case (req)
				REQ_SET: slot_value[idx] = wval;
				REQ_GET: r.value = slot_value[idx];
				default: slot_used[idx] = 1'b0;
			endcase
		end
		if ($countones(slot_used) > peak_used)
			peak_used = $countones(slot_used);
		return r;
	endfunction

	always @(posedge clk) begin : scoreboard
		slot_result_t got;
		slot_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.slot = m_tdata[IDX_W-1:0];
				got.value = m_tdata[IDX_W+VALUE_W-1:IDX_W];
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing pending (status %0d slot %0d)",
						got.status, got.slot));
				end else begin
					want = pending_results.pop_front();
					if (got.status != want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							got.status, want.status));
					if (got.slot != want.slot)
						report_mismatch($sformatf("slot_out %0d, expected %0d",
							got.slot, want.slot));
					if (got.value != want.value)
						report_mismatch($sformatf("read_value %h, expected %h",
							got.value, want.value));
				end
			end
			if (s_tvalid && s_tready) begin
				req_count[s_tuser]++;
				want = serve_request(req_t'(s_tuser), s_tdata[IDX_W-1:0],
					s_tdata[IDX_W+VALUE_W-1:IDX_W]);
				if (beat_typed)
					want = beat_want;
				pending_results.push_back(want);
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_beat(input req_t req, input logic [IDX_W-1:0] idx,
			input logic [VALUE_W-1:0] wval, input logic typed, input slot_result_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		beat_typed = typed;
		beat_want = want;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {{TDATA_PAD{1'b0}}, wval, idx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [IDX_W-1:0] pick_used_slot();
		int start;
		int hit;
		hit = -1;
		start = $urandom_range(SLOTS - 1);
		for (int k = SLOTS - 1; k >= 0; k--)
			if (slot_used[(start + k) % SLOTS])
				hit = (start + k) % SLOTS;
		if (hit < 0)
			return IDX_W'($urandom_range(63));
		return hit[IDX_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '1;
			3: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic next_request(output req_t req, output logic [IDX_W-1:0] idx,
			output logic [VALUE_W-1:0] wval);
		int roll;
		roll = $urandom_range(99);
		if (burst_left == 0) begin
			burst_mix = mix_t'($urandom_range(2));
			burst_left = $urandom_range(20, 90);
		end
		burst_left--;
		idx = pick_used_slot();
		wval = pick_value();
		if (roll < 8) begin
			req = req_t'($urandom_range(3));
			idx = IDX_W'($urandom_range(63));
		end else begin
			case (burst_mix)
				MIX_FILL:  req = roll < 80 ? REQ_ALLOC : roll < 90 ? REQ_SET : REQ_GET;
				MIX_DRAIN: req = roll < 65 ? REQ_FREE : roll < 80 ? REQ_SET :
					roll < 90 ? REQ_GET : REQ_ALLOC;
				default:   req = req_t'(roll % 4);
			endcase
		end
	endtask

	task automatic run_random(input int count);
		req_t req;
		logic [IDX_W-1:0] idx;
		logic [VALUE_W-1:0] wval;
		repeat (count) begin
			next_request(req, idx, wval);
			send_beat(req, idx, wval, 1'b0, NO_CHECK);
		end
	endtask

	initial begin
		#(TIMEOUT_CYCLES * 8);
		$display("timeout: %0d results still pending", pending_results.size());
		$display("** bitmap_slot_store: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		beat_typed = 1'b0;
		beat_want = NO_CHECK;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		burst_mix = MIX_FILL;
		burst_left = 0;
		mismatches = 0;
		results_checked = 0;
		full_replies = 0;
		unalloc_replies = 0;
		peak_used = 0;
		req_count = '{default: 0};
		slot_used = '0;
		for (int i = 0; i < SLOTS; i++)
			slot_value[i] = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].wval,
				directed_rows[i].typed, directed_rows[i].want);
		wait_drained();

		// open with a fill burst so the table-full reply shows up early
		burst_mix = MIX_FILL;
		burst_left = 90;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			run_random(PHASE_ITEMS);
			wait_drained();
		end

		// receiver holds off while the sender keeps pushing beats
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		run_random(PRESSURE_ITEMS);
		wait_drained();

		repeat (16) @(posedge clk);
		$display("covered: %0d requests (alloc %0d, set %0d, get %0d, free %0d), %0d results",
			req_count[REQ_ALLOC] + req_count[REQ_SET] + req_count[REQ_GET] +
			req_count[REQ_FREE], req_count[REQ_ALLOC], req_count[REQ_SET],
			req_count[REQ_GET], req_count[REQ_FREE], results_checked);
		$display("covered: %0d table-full, %0d unallocated-slot replies, peak occupancy %0d/%0d",
			full_replies, unalloc_replies, peak_used, SLOTS);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** bitmap_slot_store: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				pending_results.size());
			$display("** bitmap_slot_store: FAILED **");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bss_pkg.sv
hdl/bitmap_slot_store.sv
dv/bitmap_slot_store_tb.sv
